// ===== rtl/core/tmprof_pkg.sv =====
// shared types, constants and a helper function for the trapezoidal motion profile block
package tmprof_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int COORD_W    = 16;
	localparam int TIME_W     = 32;
	localparam int LEN_W      = 17;
	localparam int DIV_STEPS  = 17;
	localparam int ROOT_STEPS = 17;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [2:0] {
		PH_BEFORE = 3'd0,
		PH_ACCEL  = 3'd1,
		PH_CRUISE = 3'd2,
		PH_DECEL  = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		REG_START_X    = 3'd0,
		REG_START_Y    = 3'd1,
		REG_END_X      = 3'd2,
		REG_END_Y      = 3'd3,
		REG_SPEED      = 3'd4,
		REG_ACCEL      = 3'd5,
		REG_START_TIME = 3'd6
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_ROOT,
		ST_DT1,
		ST_DT2,
		ST_DLA,
		ST_RT,
		ST_VCR,
		ST_AREA
	} setup_state_t;

	// move geometry as seen by the datapath
	typedef struct packed {
		logic [COORD_W-1:0] sx;
		logic [COORD_W-1:0] sy;
		logic [COORD_W-1:0] adx;
		logic [COORD_W-1:0] ady;
		logic               negx;
		logic               negy;
		logic [TIME_W-1:0]  start_time;
	} geom_t;

	// profile figures derived from the configuration
	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [LEN_W-1:0] t1;
		logic [LEN_W-1:0] t2;
		logic [LEN_W:0]   tf;
		logic [15:0]      vcr;
		logic [31:0]      at1sq;
		logic [15:0]      acc;
	} prof_t;

	typedef struct packed {
		phase_t           ph;
		logic [LEN_W-1:0] m;
	} item_t;

	// one restoring division step: returns {remainder, shifted dividend with quotient bit}
	function automatic logic [2*LEN_W-1:0] div_step(input logic [LEN_W-1:0] rem,
			input logic [LEN_W-1:0] low, input logic [LEN_W-1:0] dvs);
		logic [LEN_W:0]   sh;
		logic             ge;
		logic [LEN_W:0]   diff;
		logic [LEN_W-1:0] rem_n;
		sh    = {rem, low[LEN_W-1]};
		ge    = sh >= {1'b0, dvs};
		diff  = sh - {1'b0, dvs};
		rem_n = ge ? diff[LEN_W-1:0] : sh[LEN_W-1:0];
		return {rem_n, low[LEN_W-2:0], ge};
	endfunction

endpackage

// ===== rtl/core/tmprof_setup.sv =====
// configuration registers and the iterative unit that derives length and phase times
module tmprof_setup (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tmprof_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [tmprof_pkg::CFG_DATA_W-1:0] cfg_data,
	output tmprof_pkg::geom_t                geom,
	output tmprof_pkg::prof_t                prof,
	output logic                             running
);
	import tmprof_pkg::*;

	logic [15:0] sx_q, sy_q, ex_q, ey_q, spd_q, acc_q;
	logic [31:0] st_q;

	setup_state_t state_q, state_d;

	logic [16:0] dxf, dyf, ndx, ndy;
	logic [15:0] adx, ady, spd, acc;
	logic [31:0] sqx, sqy;

	logic [33:0] sum_q, rad_q;
	logic [19:0] rem_q;
	logic [16:0] root_q;
	logic [16:0] drem_q, dvd_q;
	logic [4:0]  cnt_q;
	logic [16:0] len_q, t1_q, t2_q;
	logic [17:0] tf_q;
	logic [15:0] vcr_q;
	logic [31:0] at1sq_q;

	logic [19:0] rsh, trial, rdiff, rem_n;
	logic        rge;
	logic [16:0] root_n;
	logic [16:0] dvs;
	logic [33:0] dres;
	logic        last;
	logic [32:0] vcr_full;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q  <= '0;
			sy_q  <= '0;
			ex_q  <= '0;
			ey_q  <= '0;
			spd_q <= 16'd1;
			acc_q <= 16'd1;
			st_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_START_X:    sx_q  <= cfg_data[15:0];
				REG_START_Y:    sy_q  <= cfg_data[15:0];
				REG_END_X:      ex_q  <= cfg_data[15:0];
				REG_END_Y:      ey_q  <= cfg_data[15:0];
				REG_SPEED:      spd_q <= cfg_data[15:0];
				REG_ACCEL:      acc_q <= cfg_data[15:0];
				REG_START_TIME: st_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign dxf = {ex_q[15], ex_q} - {sx_q[15], sx_q};
	assign dyf = {ey_q[15], ey_q} - {sy_q[15], sy_q};
	assign ndx = 17'd0 - dxf;
	assign ndy = 17'd0 - dyf;
	assign adx = dxf[16] ? ndx[15:0] : dxf[15:0];
	assign ady = dyf[16] ? ndy[15:0] : dyf[15:0];
	assign spd = (spd_q == 16'd0) ? 16'd1 : spd_q;
	assign acc = (acc_q == 16'd0) ? 16'd1 : acc_q;

	// full-width squares of the move vector
	assign sqx = adx * adx;
	assign sqy = ady * ady;

	// square root step, two radicand bits per cycle
	assign rsh    = {rem_q[17:0], rad_q[33:32]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign rge    = rsh >= trial;
	assign rdiff  = rsh - trial;
	assign rem_n  = rge ? rdiff : rsh;
	assign root_n = {root_q[15:0], rge};

	assign dres = div_step(drem_q, dvd_q, dvs);
	assign last = cnt_q == 5'(DIV_STEPS - 1);
	assign vcr_full = {1'b0, acc} * {16'd0, t1_q};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: state_d = ST_IDLE;
			ST_SQX:  state_d = ST_SQY;
			ST_SQY:  state_d = ST_ROOT;
			ST_ROOT: if (last) state_d = ST_DT1;
			ST_DT1:  if (last) state_d = ST_DT2;
			ST_DT2: begin
				if (last) state_d = (t1_q >= dres[16:0]) ? ST_DLA : ST_VCR;
			end
			ST_DLA:  if (last) state_d = ST_RT;
			ST_RT:   if (last) state_d = ST_VCR;
			ST_VCR:  state_d = ST_AREA;
			ST_AREA: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
		if (cfg_we) state_d = ST_SQX;
	end

	// outputs
	always_comb begin
		running = state_q != ST_IDLE;
		case (state_q)
			ST_DT1:  dvs = {1'b0, acc};
			ST_DT2:  dvs = {1'b0, spd};
			ST_DLA:  dvs = {1'b0, acc};
			default: dvs = {1'b0, acc};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_SQX;
		else         state_q <= state_d;
	end

	// shared iteration datapath
	always_ff @(posedge clk) begin
		cnt_q <= cnt_q + 5'd1;
		case (state_q)
			ST_SQX: sum_q <= {2'b00, sqx};
			ST_SQY: begin
				rad_q  <= sum_q + {2'b00, sqy};
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= '0;
			end
			ST_ROOT, ST_RT: begin
				rad_q  <= {rad_q[31:0], 2'b00};
				rem_q  <= rem_n;
				root_q <= root_n;
				if (last) begin
					cnt_q  <= '0;
					drem_q <= '0;
					if (state_q == ST_ROOT) begin
						len_q <= root_n;
						dvd_q <= {1'b0, spd};
					end else begin
						t1_q <= root_n;
						t2_q <= root_n;
					end
				end
			end
			ST_DT1, ST_DT2, ST_DLA: begin
				drem_q <= dres[33:17];
				dvd_q  <= dres[16:0];
				if (last) begin
					cnt_q  <= '0;
					drem_q <= '0;
					dvd_q  <= len_q;
					if (state_q == ST_DT1) t1_q <= dres[16:0];
					if (state_q == ST_DT2) t2_q <= dres[16:0];
					if (state_q == ST_DLA) begin
						rad_q  <= {17'd0, dres[16:0]};
						rem_q  <= '0;
						root_q <= '0;
					end
				end
			end
			ST_VCR: begin
				vcr_q <= vcr_full[15:0];
				tf_q  <= {1'b0, t1_q} + {1'b0, t2_q};
			end
			ST_AREA: at1sq_q <= vcr_q * t1_q[15:0];
			default: ;
		endcase
	end

	assign geom.sx         = sx_q;
	assign geom.sy         = sy_q;
	assign geom.adx        = adx;
	assign geom.ady        = ady;
	assign geom.negx       = dxf[16];
	assign geom.negy       = dyf[16];
	assign geom.start_time = st_q;

	assign prof.len   = len_q;
	assign prof.t1    = t1_q;
	assign prof.t2    = t2_q;
	assign prof.tf    = tf_q;
	assign prof.vcr   = vcr_q;
	assign prof.at1sq = at1sq_q;
	assign prof.acc   = acc;

endmodule

// ===== rtl/core/tmprof_front.sv =====
// front end: takes a time sample and classifies it into a profile phase
module tmprof_front (
	input  logic                          start,
	input  logic [tmprof_pkg::TIME_W-1:0] time_now,
	input  logic                          setup_busy,
	input  logic                          fifo_full,
	input  tmprof_pkg::geom_t             geom,
	input  tmprof_pkg::prof_t             prof,
	output logic                          busy,
	output logic                          push,
	output tmprof_pkg::item_t             item
);
	import tmprof_pkg::*;

	logic signed [32:0] t, t1e, t2e, tfe;
	logic [17:0]        r;

	assign busy = setup_busy | fifo_full;
	assign push = start & ~busy;

	assign t   = $signed({1'b0, time_now}) - $signed({1'b0, geom.start_time});
	assign t1e = $signed({16'd0, prof.t1});
	assign t2e = $signed({16'd0, prof.t2});
	assign tfe = $signed({15'd0, prof.tf});
	assign r   = prof.tf - t[17:0];

	always_comb begin
		if (t[32] || t == 33'sd0)  item.ph = PH_BEFORE;
		else if (t < t1e)          item.ph = PH_ACCEL;
		else if (t < t2e)          item.ph = PH_CRUISE;
		else if (t < tfe)          item.ph = PH_DECEL;
		else                       item.ph = PH_DONE;
		// decel works on time remaining
		item.m = (item.ph == PH_DECEL) ? r[16:0] : t[16:0];
	end

endmodule

// ===== rtl/core/tmprof_fifo.sv =====
// short queue of classified words between front and back end
module tmprof_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tmprof_pkg::item_t wdata,
	input  logic              pop,
	output tmprof_pkg::item_t rdata,
	output logic              empty,
	output logic              full
);
	import tmprof_pkg::*;

	item_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wp_q, rp_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  do_pop;

	assign empty  = cnt_q == '0;
	assign full   = cnt_q == FIFO_CNT_W'(FIFO_DEPTH);
	assign do_pop = pop & ~empty;
	assign rdata  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (do_pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + FIFO_CNT_W'(push) - FIFO_CNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

endmodule

// ===== rtl/core/tmprof_back.sv =====
// back end: speed, distance and position pipeline, one word per cycle
module tmprof_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           vld_in,
	input  tmprof_pkg::item_t              item,
	input  tmprof_pkg::geom_t              geom,
	input  tmprof_pkg::prof_t              prof,
	output logic                           done,
	output logic [tmprof_pkg::COORD_W-1:0] pos_x,
	output logic [tmprof_pkg::COORD_W-1:0] pos_y,
	output logic [15:0]                    speed_now,
	output logic [16:0]                    accel_now,
	output logic [16:0]                    distance,
	output logic [2:0]                     phase
);
	import tmprof_pkg::*;

	typedef struct packed {
		phase_t      ph;
		logic [15:0] spd;
		logic [16:0] acc;
		logic [16:0] dst;
	} side_t;

	logic        vld_s1, vld_s2, vld_s3;
	phase_t      ph_s1, ph_s2, ph_s3;
	logic [16:0] m_s1;
	logic [32:0] p1_s1, p1_s2;
	logic [47:0] p2_s2;
	logic [15:0] spd_s3;
	logic [16:0] acc_s3, dist_s3;

	logic [15:0] mx;
	logic signed [50:0] d2;
	logic [49:0] half;
	logic [16:0] dist_c;
	logic [15:0] spd_c;
	logic [16:0] acc_c;
	logic [32:0] nx, ny;

	logic        vld_d  [DIV_STEPS+1];
	side_t       side_d [DIV_STEPS+1];
	logic [16:0] xrem_d [DIV_STEPS+1];
	logic [16:0] xlow_d [DIV_STEPS+1];
	logic [16:0] yrem_d [DIV_STEPS+1];
	logic [16:0] ylow_d [DIV_STEPS+1];
	logic [33:0] xres   [DIV_STEPS];
	logic [33:0] yres   [DIV_STEPS];

	logic        done_q;
	logic [15:0] pos_x_q, pos_y_q, spd_q;
	logic [16:0] acc_q, dist_q;
	logic [2:0]  ph_q;
	logic [15:0] qx, qy;

	// cruise uses the cruise speed, the ramps use the acceleration
	assign mx = (item.ph == PH_CRUISE) ? prof.vcr : prof.acc;

	always_comb begin
		case (ph_s2)
			PH_ACCEL:  d2 = $signed({3'd0, p2_s2});
			PH_CRUISE: d2 = $signed({17'd0, p1_s2, 1'b0}) - $signed({19'd0, prof.at1sq});
			PH_DECEL:  d2 = $signed({33'd0, prof.len, 1'b0}) - $signed({3'd0, p2_s2});
			PH_DONE:   d2 = $signed({33'd0, prof.len, 1'b0});
			default:   d2 = '0;
		endcase
		half = d2[50:1];
		if (d2[50])             dist_c = '0;
		else if (|half[49:17])  dist_c = '1;
		else                    dist_c = half[16:0];
		case (ph_s2)
			PH_ACCEL, PH_DECEL: spd_c = (|p1_s2[32:16]) ? 16'hFFFF : p1_s2[15:0];
			PH_CRUISE:          spd_c = prof.vcr;
			default:            spd_c = '0;
		endcase
		case (ph_s2)
			PH_ACCEL: acc_c = {1'b0, prof.acc};
			PH_DECEL: acc_c = 17'd0 - {1'b0, prof.acc};
			default:  acc_c = '0;
		endcase
	end

	assign nx = {1'b0, geom.adx} * {16'd0, dist_s3};
	assign ny = {1'b0, geom.ady} * {16'd0, dist_s3};

	always_comb begin
		for (int k = 0; k < DIV_STEPS; k++) begin
			xres[k] = div_step(xrem_d[k], xlow_d[k], prof.len);
			yres[k] = div_step(yrem_d[k], ylow_d[k], prof.len);
		end
	end

	assign qx = side_d[DIV_STEPS].ph == PH_BEFORE ? 16'd0 : xlow_d[DIV_STEPS][15:0];
	assign qy = side_d[DIV_STEPS].ph == PH_BEFORE ? 16'd0 : ylow_d[DIV_STEPS][15:0];

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			for (int k = 0; k <= DIV_STEPS; k++) vld_d[k] <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1   <= vld_in;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			vld_d[0] <= vld_s3;
			for (int k = 0; k < DIV_STEPS; k++) vld_d[k+1] <= vld_d[k];
			done_q <= vld_d[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		ph_s1 <= item.ph;
		m_s1  <= item.m;
		p1_s1 <= {1'b0, mx} * {16'd0, item.m};

		ph_s2 <= ph_s1;
		p1_s2 <= p1_s1;
		p2_s2 <= p1_s1[31:0] * m_s1[15:0];

		ph_s3   <= ph_s2;
		spd_s3  <= spd_c;
		acc_s3  <= acc_c;
		dist_s3 <= dist_c;

		side_d[0] <= '{ph: ph_s3, spd: spd_s3, acc: acc_s3, dst: dist_s3};
		xrem_d[0] <= {1'b0, nx[32:17]};
		xlow_d[0] <= nx[16:0];
		yrem_d[0] <= {1'b0, ny[32:17]};
		ylow_d[0] <= ny[16:0];
		for (int k = 0; k < DIV_STEPS; k++) begin
			side_d[k+1] <= side_d[k];
			xrem_d[k+1] <= xres[k][33:17];
			xlow_d[k+1] <= xres[k][16:0];
			yrem_d[k+1] <= yres[k][33:17];
			ylow_d[k+1] <= yres[k][16:0];
		end

		// zero length leaves the start point
		if (prof.len == '0) begin
			pos_x_q <= geom.sx;
			pos_y_q <= geom.sy;
		end else begin
			pos_x_q <= geom.negx ? geom.sx - qx : geom.sx + qx;
			pos_y_q <= geom.negy ? geom.sy - qy : geom.sy + qy;
		end
		spd_q  <= side_d[DIV_STEPS].spd;
		acc_q  <= side_d[DIV_STEPS].acc;
		dist_q <= side_d[DIV_STEPS].dst;
		ph_q   <= side_d[DIV_STEPS].ph;
	end

	assign done      = done_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign speed_now = spd_q;
	assign accel_now = acc_q;
	assign distance  = dist_q;
	assign phase     = ph_q;

endmodule

// ===== rtl/core/trapezoidal_motion_profile.sv =====
// top level of the trapezoidal motion profile set-point generator
// A word is taken at each rising edge where start is high and busy is low; one set-point
// word comes back on the result ports for one cycle with done high, and words may be
// started every cycle while busy is low. The receiver cannot hold results off, so the
// back end never stalls and the queue between front and back never fills in normal use;
// busy is therefore high only while the profile setup runs. The setup runs after reset
// and again after every configuration write: it squares and sums the move vector, takes
// the square root and does the phase-time divisions one bit per cycle on a single shared
// unit, and a triangular profile needs a further division and square root.
module trapezoidal_motion_profile (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [tmprof_pkg::TIME_W-1:0]     time_now,
	input  logic                             cfg_we,
	input  logic [tmprof_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [tmprof_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                             done,
	output logic [tmprof_pkg::COORD_W-1:0]    pos_x,
	output logic [tmprof_pkg::COORD_W-1:0]    pos_y,
	output logic [15:0]                      speed_now,
	output logic [16:0]                      accel_now,
	output logic [16:0]                      distance,
	output logic [2:0]                       phase
);
	import tmprof_pkg::*;

	geom_t geom;
	prof_t prof;
	item_t in_item, q_item;
	logic  setup_busy, push, q_empty, q_full;

	// config registers and derived profile times
	tmprof_setup u_setup (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.geom     (geom),
		.prof     (prof),
		.running  (setup_busy)
	);

	// phase classification of each incoming word
	tmprof_front u_front (
		.start      (start),
		.time_now   (time_now),
		.setup_busy (setup_busy),
		.fifo_full  (q_full),
		.geom       (geom),
		.prof       (prof),
		.busy       (busy),
		.push       (push),
		.item       (in_item)
	);

	// decouples front from back
	tmprof_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (in_item),
		.pop    (1'b1),
		.rdata  (q_item),
		.empty  (q_empty),
		.full   (q_full)
	);

	// arithmetic pipeline, pops whenever the queue holds a word
	tmprof_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld_in    (~q_empty),
		.item      (q_item),
		.geom      (geom),
		.prof      (prof),
		.done      (done),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.speed_now (speed_now),
		.accel_now (accel_now),
		.distance  (distance),
		.phase     (phase)
	);

endmodule

// ===== rtl/core/tmprof_checker.sv =====
// port-level checks for the trapezoidal motion profile block and its bind
module tmprof_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        done,
	input logic [15:0] speed_now,
	input logic [16:0] accel_now,
	input logic [16:0] distance,
	input logic [2:0]  phase
);
	import tmprof_pkg::*;

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> phase <= PH_DONE)
		else $error("phase out of range");

	a_rest_still: assert property (@(posedge clk) disable iff (!arst_n)
		done && (phase == PH_BEFORE || phase == PH_DONE) |-> speed_now == '0 && accel_now == '0)
		else $error("motion outside the move");

	a_before_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done && phase == PH_BEFORE |-> distance == '0)
		else $error("distance before start");

	a_cruise_flat: assert property (@(posedge clk) disable iff (!arst_n)
		done && phase == PH_CRUISE |-> accel_now == '0)
		else $error("acceleration while cruising");

endmodule

bind trapezoidal_motion_profile tmprof_checker u_tmprof_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.done      (done),
	.speed_now (speed_now),
	.accel_now (accel_now),
	.distance  (distance),
	.phase     (phase)
);
